>>> hw/rtl/srtw_pkg.sv
package srtw_pkg;

  // fixed target storage and symbols
  localparam int unsigned TargetSlots = 9;
  localparam logic [7:0] StarChar = 8'd42;
  localparam logic [3:0] MaxLen = 4'd9;

  // configuration register indexes
  localparam logic [1:0] CfgTargetLow = 2'd0;
  localparam logic [1:0] CfgTargetHigh = 2'd1;
  localparam logic [1:0] CfgTargetLen = 2'd2;

  // configuration reset values ("ALGORITMO")
  localparam logic [63:0] TargetLowReset = 64'h4D54_4952_4F47_4C41;
  localparam logic [7:0] TargetHighReset = 8'd79;
  localparam logic [3:0] TargetLenReset = 4'd9;

  typedef struct packed {
    logic [7:0] in_char;
    logic is_final;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic run_end;
    logic word_done;
    logic word_ok;
  } out_item_t;

  typedef enum logic [1:0] {
    StIdle,
    StHead,
    StStar
  } ctrl_state_e;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic emit_head;
    logic emit_star;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic slot_free;
    logic match;
    logic pop_more;
  } dp_status_t;

endpackage

>>> hw/rtl/srtw_ctrl.sv
module srtw_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  srtw_pkg::dp_status_t  status_i,
  output srtw_pkg::ctrl_cmd_t   cmd_o,
  output logic                  in_stall_o
);
  import srtw_pkg::*;

  ctrl_state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          state_d = StHead;
        end
      end
      StHead: begin
        if (status_i.slot_free) begin
          state_d = status_i.match ? StStar : StIdle;
        end
      end
      StStar: begin
        if (status_i.slot_free && !status_i.pop_more) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // commands
  always_comb begin
    cmd_o = '0;
    in_stall_o = 1'b1;
    case (state_q)
      StIdle: begin
        in_stall_o = 1'b0;
        cmd_o.load = in_valid_i;
      end
      StHead: begin
        cmd_o.emit_head = status_i.slot_free;
      end
      StStar: begin
        cmd_o.emit_star = status_i.slot_free;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

endmodule

>>> hw/rtl/srtw_dp.sv
module srtw_dp #(
  parameter int unsigned MAX_WORD = 9
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  srtw_pkg::in_item_t    in_data_i,
  input  srtw_pkg::ctrl_cmd_t   cmd_i,
  output srtw_pkg::dp_status_t  status_o,
  input  logic                  cfg_valid_i,
  input  logic [1:0]            cfg_index_i,
  input  logic [63:0]           cfg_data_i,
  input  logic                  out_stall_i,
  output logic                  out_valid_o,
  output srtw_pkg::out_item_t   out_data_o
);
  import srtw_pkg::*;

  localparam int unsigned SCW = $clog2(MAX_WORD + 1);
  localparam int unsigned IW = (MAX_WORD > 1) ? $clog2(MAX_WORD) : 1;
  localparam logic [SCW-1:0] Depth = SCW'(MAX_WORD);

  logic [63:0] tgt_low_q;
  logic [7:0] tgt_high_q;
  logic [3:0] tgt_len_q;

  logic [7:0] ch_q;
  logic fin_q;
  logic [3:0] mp_q, mp_d;
  logic [SCW-1:0] sc_q, sc_d;
  logic ovf_q, ovf_d;
  logic [7:0] stack_q [MAX_WORD];

  out_item_t out_q, out_d;
  logic out_valid_q;

  logic [3:0] len;
  logic [7:0] tgt_cur;
  logic [7:0] top_char;
  logic [SCW-1:0] sc_dec;
  logic mp_in_word;
  logic match;
  logic pop_more;
  logic push_en;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tgt_low_q <= TargetLowReset;
      tgt_high_q <= TargetHighReset;
      tgt_len_q <= TargetLenReset;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgTargetLow: tgt_low_q <= cfg_data_i;
        CfgTargetHigh: tgt_high_q <= cfg_data_i[7:0];
        CfgTargetLen: tgt_len_q <= cfg_data_i[3:0];
        default: begin
        end
      endcase
    end
  end

  // target lookup and stack top compare
  assign len = (tgt_len_q > MaxLen) ? MaxLen : tgt_len_q;
  assign tgt_cur = (mp_q < 4'd8) ? tgt_low_q[{mp_q[2:0], 3'b000} +: 8] : tgt_high_q;
  assign sc_dec = sc_q - SCW'(1);
  assign top_char = stack_q[sc_dec[IW-1:0]];
  assign mp_in_word = mp_q < len;
  assign match = mp_in_word && (ch_q == tgt_cur);
  assign pop_more = (sc_q != '0) && mp_in_word && (top_char == tgt_cur);
  assign push_en = cmd_i.emit_head && !match && (sc_q < Depth);

  assign status_o.slot_free = !out_valid_q || !out_stall_i;
  assign status_o.match = match;
  assign status_o.pop_more = pop_more;

  // word state and result update
  always_comb begin
    mp_d = mp_q;
    sc_d = sc_q;
    ovf_d = ovf_q;
    out_d = out_q;
    if (cmd_i.emit_head) begin
      out_d.out_char = ch_q;
      out_d.run_end = !match;
      out_d.word_done = fin_q && !match;
      out_d.word_ok = 1'b0;
      if (match) begin
        mp_d = mp_q + 4'd1;
      end else begin
        if (sc_q < Depth) begin
          sc_d = sc_q + SCW'(1);
        end else begin
          ovf_d = 1'b1;
        end
        if (fin_q) begin
          mp_d = '0;
          sc_d = '0;
          ovf_d = 1'b0;
        end
      end
    end else if (cmd_i.emit_star) begin
      out_d.out_char = StarChar;
      out_d.run_end = !pop_more;
      out_d.word_done = fin_q && !pop_more;
      out_d.word_ok = fin_q && !pop_more && (sc_q == '0) && (mp_q == len) && !ovf_q;
      if (pop_more) begin
        sc_d = sc_dec;
        mp_d = mp_q + 4'd1;
      end else if (fin_q) begin
        mp_d = '0;
        sc_d = '0;
        ovf_d = 1'b0;
      end
    end
  end

  // control state of the word and output slot
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mp_q <= '0;
      sc_q <= '0;
      ovf_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      mp_q <= mp_d;
      sc_q <= sc_d;
      ovf_q <= ovf_d;
      if (cmd_i.emit_head || cmd_i.emit_star) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      ch_q <= in_data_i.in_char;
      fin_q <= in_data_i.is_final;
    end
    out_q <= out_d;
  end

  // hold stack
  always_ff @(posedge clk_i) begin
    if (push_en) begin
      stack_q[sc_q[IW-1:0]] <= ch_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o = out_q;

endmodule

>>> hw/rtl/stack_reorder_to_target_word.sv
// an accepted item is registered, then its first result goes into the output register
// an item yielding k results (1 to 10) keeps the input stalled until its last result,
// one result per cycle through the single output register unless the output stalls
// reset: asynchronous, clears the word state and output valid, target registers
// return to "ALGORITMO" with length 9; stack contents need no clearing
module stack_reorder_to_target_word #(
  parameter int unsigned MAX_WORD = 9
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  srtw_pkg::in_item_t   in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output srtw_pkg::out_item_t  out_data_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [1:0]           cfg_index_i,
  input  logic [63:0]          cfg_data_i
);
  import srtw_pkg::*;

  ctrl_cmd_t cmd;
  dp_status_t status;

  assign cfg_ready_o = 1'b1;

  // sequencer
  srtw_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .status_i   (status),
    .cmd_o      (cmd),
    .in_stall_o (in_stall_o)
  );

  // stack, match position and output register
  srtw_dp #(
    .MAX_WORD (MAX_WORD)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

`ifndef SYNTHESIS
  // an accepted item keeps the input stalled while it is worked
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input not stalled after transaction");

  // a result that is not the last of its item means the item is still in work
  a_item_in_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_data_o.run_end) |-> in_stall_o)
    else $error("input open while item results pending");

  // verdict only on the last result of an item
  a_done_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.word_done) |-> out_data_o.run_end)
    else $error("word_done without run_end");

  // success only together with a verdict
  a_ok_needs_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.word_ok) |-> out_data_o.word_done)
    else $error("word_ok without word_done");
`endif

endmodule
